### src/trrq_pkg.sv
// Package with types, codes and constants of the timed read request queue.
package trrq_pkg;

	localparam int unsigned QueueDepthDefault = 32;

	typedef enum logic [2:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP        = 3'd2,
		OP_PEEK       = 3'd3,
		OP_FLUSH_MUS  = 3'd4,
		OP_FLUSH_STR  = 3'd5,
		OP_TICK       = 3'd6,
		OP_NOP        = 3'd7
	} op_e;

	typedef enum logic [1:0] {
		FLT_OK    = 2'd0,
		FLT_FULL  = 2'd1,
		FLT_EMPTY = 2'd2
	} fault_e;

	typedef enum logic [1:0] {
		XF_IDLE = 2'd0,
		XF_BUSY = 2'd1,
		XF_DONE = 2'd2
	} xfer_e;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_ABORTED   = 2'd1;
	localparam logic [1:0] ERR_NOT_READY = 2'd2;
	localparam logic [1:0] ERR_HARD      = 2'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] start_sector;
		logic [15:0] sector_count;
		logic [31:0] buffer_addr;
		logic [2:0]  request_kind;
		logic [31:0] due_tick;
		logic [1:0]  drive_error;
		logic        drive_busy;
		logic        drive_accepts;
	} req_in_t;

	typedef struct packed {
		logic        read_issue;
		logic        read_to_io;
		logic        abort_drive;
		logic [31:0] out_sector;
		logic [15:0] out_count;
		logic [31:0] out_buffer;
		logic [2:0]  out_kind;
		logic [31:0] head_due;
		logic [5:0]  queue_count;
		logic [1:0]  transfer_state;
		logic        data_ready;
		logic [1:0]  fault;
	} req_out_t;

	// One stored request, including its due tick.
	typedef struct packed {
		logic [31:0] sector;
		logic [15:0] count;
		logic [31:0] buffer;
		logic [2:0]  kind;
		logic [31:0] due;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_FL_READ,
		ST_FL_WRITE,
		ST_HEAD,
		ST_DONE
	} state_e;

	typedef struct packed {
		logic capture;
		logic exec;
		logic fl_init;
		logic fl_read;
		logic fl_step;
		logic fl_end;
		logic head_read;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic is_flush;
		logic fl_more;
	} status_t;

	function automatic logic kind_dropped(input logic [2:0] op, input logic [2:0] k);
		if (op == OP_FLUSH_MUS)
			return (k == 3'd1) || (k == 3'd2);
		return k == 3'd3;
	endfunction

endpackage

### src/trrq_ctrl.sv
// Controller state machine of the timed read request queue.
module trrq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  trrq_pkg::status_t sts,
	output trrq_pkg::cmd_t    cmd
);
	import trrq_pkg::*;

	state_e state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (sts.is_flush) begin
					cmd.fl_init = 1'b1;
					state_d = ST_FL_READ;
				end else begin
					cmd.exec = 1'b1;
					state_d = ST_HEAD;
				end
			end
			ST_FL_READ: begin
				if (sts.fl_more) begin
					cmd.fl_read = 1'b1;
					state_d = ST_FL_WRITE;
				end else begin
					cmd.fl_end = 1'b1;
					state_d = ST_HEAD;
				end
			end
			ST_FL_WRITE: begin
				cmd.fl_step = 1'b1;
				state_d = ST_FL_READ;
			end
			ST_HEAD: begin
				cmd.head_read = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) cmd.emit |=> !busy)
		else $error("busy after emit");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.capture |=> busy)
		else $error("not busy after capture");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.head_read |=> cmd.emit)
		else $error("head read without emit");
endmodule

### src/trrq_dp.sv
// Datapath of the timed read request queue: entry memory, indices and transfer state.
module trrq_dp #(
	parameter int unsigned QUEUE_DEPTH = trrq_pkg::QueueDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  trrq_pkg::req_in_t  req,
	input  trrq_pkg::cmd_t     cmd,
	output trrq_pkg::status_t  sts,
	output logic               done,
	output trrq_pkg::req_out_t result
);
	import trrq_pkg::*;

	localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IW-1:0] LastIdx = IW'(QUEUE_DEPTH - 1);

	entry_t mem [QUEUE_DEPTH];
	entry_t rd_q;

	req_in_t  in_q;
	req_out_t res_q;
	logic [IW-1:0] head_q, tail_q;
	logic [CW-1:0] total_q;
	logic [31:0] tick_q;
	logic [1:0]  fst_q;
	logic [2:0]  fkind_q;
	logic [31:0] fsec_q;
	logic [15:0] fcnt_q;
	logic [31:0] fbuf_q;
	logic [CW-1:0] rcnt_q, wcnt_q;
	logic [IW-1:0] ridx_q, widx_q;
	logic done_q;

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] i);
		return (i == LastIdx) ? '0 : i + 1'b1;
	endfunction
	function automatic logic [IW-1:0] prv(input logic [IW-1:0] i);
		return (i == '0) ? LastIdx : i - 1'b1;
	endfunction

	// Read address mux: flush walks the read pointer, otherwise the head.
	logic [IW-1:0] raddr;
	logic          full, empty;
	logic          we;
	logic [IW-1:0] waddr;
	entry_t        wdata;

	assign full  = (total_q == CW'(QUEUE_DEPTH));
	assign empty = (total_q == '0);
	assign raddr = cmd.fl_read ? ridx_q : head_q;

	assign sts.is_flush = (in_q.op == OP_FLUSH_MUS) || (in_q.op == OP_FLUSH_STR);
	assign sts.fl_more  = (rcnt_q != total_q);

	// Entry read: head is pre-read at capture; flush reads each element.
	always_ff @(posedge clk) begin
		if (cmd.capture || cmd.fl_read || cmd.head_read || cmd.exec)
			rd_q <= mem[raddr];
		if (we) mem[waddr] <= wdata;
	end

	// Tick decisions, based on the head read taken at capture.
	logic hard, usable, issue, known;
	logic [1:0] st_after_err;
	logic do_requeue;
	always_comb begin
		hard = in_q.drive_error == ERR_HARD;
		usable = (in_q.drive_error == ERR_NONE) || (in_q.drive_error == ERR_ABORTED);
		do_requeue = hard && (fst_q != XF_IDLE) && !full;
		st_after_err = (hard || fst_q == XF_DONE) ? XF_IDLE : fst_q;
		known = (rd_q.kind >= 3'd1) && (rd_q.kind <= 3'd5);
		// A hard error leaves the drive unusable, so nothing issues on that tick.
		issue = !empty && usable && (st_after_err == XF_IDLE) && (rd_q.due <= tick_q)
			&& known && in_q.drive_accepts;
	end

	always_comb begin
		we = 1'b0;
		waddr = tail_q;
		wdata = '{in_q.start_sector, in_q.sector_count, in_q.buffer_addr,
			in_q.request_kind, in_q.due_tick};
		if (cmd.exec) begin
			if (in_q.op == OP_PUSH_BACK && !full) begin
				we = 1'b1;
			end else if (in_q.op == OP_PUSH_FRONT && !full) begin
				we = 1'b1;
				waddr = prv(head_q);
			end else if (in_q.op == OP_TICK && do_requeue) begin
				we = 1'b1;
				waddr = prv(head_q);
				wdata = '{fsec_q, fcnt_q, fbuf_q, fkind_q, tick_q};
			end
		end else if (cmd.fl_step && !kind_dropped(in_q.op, rd_q.kind)) begin
			we = 1'b1;
			waddr = widx_q;
			wdata = rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			total_q <= '0;
			tick_q <= '0;
			fst_q <= XF_IDLE;
			fkind_q <= '0;
			fsec_q <= '0;
			fcnt_q <= '0;
			fbuf_q <= '0;
			done_q <= 1'b0;
			rcnt_q <= '0;
			wcnt_q <= '0;
			ridx_q <= '0;
			widx_q <= '0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.exec) begin
				case (in_q.op)
					OP_PUSH_BACK: if (!full) begin
						tail_q <= nxt(tail_q);
						total_q <= total_q + 1'b1;
					end
					OP_PUSH_FRONT: if (!full) begin
						head_q <= prv(head_q);
						total_q <= total_q + 1'b1;
					end
					OP_POP: if (!empty) begin
						head_q <= nxt(head_q);
						total_q <= total_q - 1'b1;
					end
					OP_TICK: begin
						tick_q <= tick_q + 32'd1;
						if (do_requeue) begin
							head_q <= prv(head_q);
							total_q <= total_q + 1'b1;
						end
						if (issue) begin
							fsec_q <= rd_q.sector;
							fcnt_q <= rd_q.count;
							fbuf_q <= rd_q.buffer;
							fkind_q <= rd_q.kind;
							fst_q <= XF_BUSY;
							head_q <= nxt(head_q);
							total_q <= total_q - 1'b1;
						end else begin
							if (st_after_err == XF_IDLE && fst_q != XF_IDLE)
								fkind_q <= '0;
							if (st_after_err != XF_IDLE && !in_q.drive_busy)
								fst_q <= XF_DONE;
							else
								fst_q <= st_after_err;
						end
					end
					default: ;
				endcase
			end
			if (cmd.fl_init) begin
				rcnt_q <= '0;
				wcnt_q <= '0;
				ridx_q <= head_q;
				widx_q <= head_q;
			end
			if (cmd.fl_read) begin
				rcnt_q <= rcnt_q + 1'b1;
				ridx_q <= nxt(ridx_q);
			end
			if (cmd.fl_step && !kind_dropped(in_q.op, rd_q.kind)) begin
				wcnt_q <= wcnt_q + 1'b1;
				widx_q <= nxt(widx_q);
			end
			if (cmd.fl_end) begin
				total_q <= wcnt_q;
				tail_q <= widx_q;
			end
		end
	end

	// Input capture and result assembly.
	always_ff @(posedge clk) begin
		if (cmd.capture) in_q <= req;
		if (cmd.exec) begin
			res_q <= '0;
			case (in_q.op)
				OP_PUSH_BACK, OP_PUSH_FRONT: if (full) res_q.fault <= FLT_FULL;
				OP_POP, OP_PEEK: begin
					if (empty) res_q.fault <= FLT_EMPTY;
					else begin
						res_q.out_sector <= rd_q.sector;
						res_q.out_count <= rd_q.count;
						res_q.out_buffer <= rd_q.buffer;
						res_q.out_kind <= rd_q.kind;
					end
				end
				OP_TICK: begin
					res_q.abort_drive <= hard;
					if (hard && fst_q != XF_IDLE && full) res_q.fault <= FLT_FULL;
					if (issue) begin
						res_q.read_issue <= 1'b1;
						res_q.read_to_io <= (rd_q.kind == 3'd1) || (rd_q.kind == 3'd2);
						res_q.out_sector <= rd_q.sector;
						res_q.out_count <= rd_q.count;
						res_q.out_buffer <= rd_q.buffer;
						res_q.out_kind <= rd_q.kind;
					end
				end
				default: ;
			endcase
		end
		if (cmd.fl_end) res_q <= '0;
	end

	always_comb begin
		result = res_q;
		result.head_due = empty ? 32'd0 : rd_q.due;
		result.queue_count = 6'(total_q);
		result.transfer_state = fst_q;
		result.data_ready = (fst_q == XF_DONE) && (fkind_q == 3'd4);
	end
	assign done = done_q;

	assert property (@(posedge clk) disable iff (!arst_n) total_q <= CW'(QUEUE_DEPTH))
		else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && in_q.op == OP_TICK) |=> tick_q == $past(tick_q) + 32'd1)
		else $error("tick not advanced");
	assert property (@(posedge clk) disable iff (!arst_n) fst_q != 2'd3)
		else $error("bad transfer state");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.fl_end |=> total_q <= $past(total_q))
		else $error("flush grew queue");
endmodule

### src/timed_read_request_queue_core.sv
// Top level of the timed read request queue.
// A command is taken when start is high and busy is low; its fields come on
// req. Push, pop, peek and tick step through the idle, execute, head and done
// states; a flush adds a read and a write state for each queued entry, as the
// compaction walk reads and writes the entry memory in turn.
// The result appears on res for exactly one cycle with done high; busy is
// already low in that cycle, so the next command can be taken at its end.
// The receiver cannot stall; it must take each result in the cycle it is shown.
// Reset clears the queue indices, the entry count, the tick counter and the
// transfer state; entry storage is not cleared and needs no clearing pass.
// Tick runs the dispatcher: hard error abort and requeue at the front, then
// issue of a due head to the drive when it accepts.
// Kinds one and two route to I/O memory, three to five to main memory.
module timed_read_request_queue_core #(
	parameter int unsigned QUEUE_DEPTH = trrq_pkg::QueueDepthDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  trrq_pkg::req_in_t  req,
	output logic               done,
	output trrq_pkg::req_out_t res
);
	import trrq_pkg::*;

	cmd_t    cmd;
	status_t sts;

	trrq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
	);

	trrq_dp #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .req(req), .cmd(cmd), .sts(sts),
		.done(done), .result(res)
	);
endmodule

### tb/timed_read_request_queue_core_tb.sv
// Testbench for the timed read request queue: directed and random commands, scoreboard check.
`timescale 1ns / 1ps

module timed_read_request_queue_core_tb;
	import trrq_pkg::*;

	localparam int Depth = 32;

	// Predicts each result of the queue and holds those not yet seen.
	class queue_scoreboard;
		entry_t slots[Depth];
		bit [4:0] head_idx;
		bit [4:0] tail_idx;
		int unsigned total;
		bit [31:0] ticks;
		xfer_e flight;
		entry_t flying;
		req_out_t pending[$];
		int errors;

		function void clear();
			head_idx = 0;
			tail_idx = 0;
			total = 0;
			ticks = 0;
			flight = XF_IDLE;
			flying = '0;
			pending.delete();
			errors = 0;
		endfunction

		function bit add_front(entry_t e);
			if (total >= Depth)
				return 0;
			head_idx = head_idx - 1;
			slots[head_idx] = e;
			total++;
			return 1;
		endfunction

		function void drop_kinds(bit [2:0] ka, bit [2:0] kb);
			int w;
			entry_t e;
			w = 0;
			for (int r = 0; r < total; r++) begin
				e = slots[(head_idx + r) % Depth];
				if (e.kind != ka && e.kind != kb) begin
					slots[(head_idx + w) % Depth] = e;
					w++;
				end
			end
			total = w;
			tail_idx = (head_idx + w) % Depth;
		endfunction

		function void note_command(req_in_t c);
			req_out_t r;
			entry_t e;
			bit started;
			r = '0;
			e.sector = c.start_sector;
			e.count = c.sector_count;
			e.buffer = c.buffer_addr;
			e.kind = c.request_kind;
			e.due = c.due_tick;
			case (op_e'(c.op))
				OP_PUSH_BACK: begin
					if (total >= Depth) begin
						r.fault = FLT_FULL;
					end else begin
						slots[tail_idx] = e;
						tail_idx++;
						total++;
					end
				end
				OP_PUSH_FRONT: if (!add_front(e)) r.fault = FLT_FULL;
				OP_POP, OP_PEEK: begin
					if (total == 0) begin
						r.fault = FLT_EMPTY;
					end else begin
						r.out_sector = slots[head_idx].sector;
						r.out_count = slots[head_idx].count;
						r.out_buffer = slots[head_idx].buffer;
						r.out_kind = slots[head_idx].kind;
						if (c.op == OP_POP) begin
							head_idx++;
							total--;
						end
					end
				end
				OP_FLUSH_MUS: drop_kinds(3'd1, 3'd2);
				OP_FLUSH_STR: drop_kinds(3'd3, 3'd3);
				OP_TICK: begin
					started = 0;
					if (c.drive_error == ERR_HARD) begin
						r.abort_drive = 1;
						if (flight != XF_IDLE) begin
							e = flying;
							e.due = ticks;
							if (!add_front(e)) r.fault = FLT_FULL;
							flight = XF_IDLE;
							flying.kind = 0;
						end
					end
					if (flight == XF_DONE) begin
						flight = XF_IDLE;
						flying.kind = 0;
					end
					if (total > 0 && slots[head_idx].due <= ticks
							&& c.drive_error < ERR_NOT_READY
							&& flight == XF_IDLE && slots[head_idx].kind >= 3'd1
							&& slots[head_idx].kind <= 3'd5 && c.drive_accepts) begin
						flying = slots[head_idx];
						r.read_issue = 1;
						r.read_to_io = flying.kind == 3'd1 || flying.kind == 3'd2;
						r.out_sector = flying.sector;
						r.out_count = flying.count;
						r.out_buffer = flying.buffer;
						r.out_kind = flying.kind;
						flight = XF_BUSY;
						head_idx++;
						total--;
						started = 1;
					end
					if (flight != XF_IDLE && !started && !c.drive_busy)
						flight = XF_DONE;
					ticks++;
				end
				default: ;
			endcase
			r.head_due = total > 0 ? slots[head_idx].due : 32'd0;
			r.queue_count = 6'(total);
			r.transfer_state = flight;
			r.data_ready = flight == XF_DONE && flying.kind == 3'd4;
			pending.push_back(r);
		endfunction

		function void check_result(req_out_t got);
			req_out_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %h actual %h", want, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_in_t req;
	req_out_t res;
	queue_scoreboard board;
	int send_idle;

	timed_read_request_queue_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req(req), .done(done), .res(res)
	);

	always #5 clk = ~clk;

	always @(posedge clk)
		if (arst_n && done) board.check_result(res);

	task automatic send(req_in_t c);
		while ($urandom_range(99) < send_idle) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= c;
		// Busy only changes at a rising edge, so a low level at the falling edge
		// means the next rising edge takes the transaction.
		@(negedge clk);
		while (busy) @(negedge clk);
		@(posedge clk);
		board.note_command(c);
	endtask

	function automatic req_in_t rand_cmd(bit [2:0] op);
		req_in_t c;
		c.op = op;
		c.start_sector = $urandom;
		c.sector_count = 16'($urandom);
		c.buffer_addr = $urandom;
		c.request_kind = 3'($urandom_range(7));
		// Mostly near-term due ticks so that the dispatcher actually issues.
		c.due_tick = $urandom_range(3) == 0 ? $urandom : board.ticks + $urandom_range(8) - 2;
		c.drive_error = $urandom_range(9) == 0 ? ERR_HARD : $urandom_range(3) == 0 ?
			2'($urandom_range(2)) : ERR_NONE;
		c.drive_busy = 1'($urandom_range(1));
		c.drive_accepts = $urandom_range(3) != 0;
		return c;
	endfunction

	function automatic bit [2:0] rand_op();
		int p;
		p = $urandom_range(99);
		if (p < 30) return OP_PUSH_BACK;
		if (p < 38) return OP_PUSH_FRONT;
		if (p < 50) return OP_POP;
		if (p < 56) return OP_PEEK;
		if (p < 59) return OP_FLUSH_MUS;
		if (p < 62) return OP_FLUSH_STR;
		if (p < 97) return OP_TICK;
		return OP_NOP;
	endfunction

	task automatic drain();
		int guard;
		guard = 0;
		start <= 1'b0;
		while (board.pending.size() != 0 && guard < 10000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	initial begin
		#20_000_000;
		$display("timed_read_request_queue_core_tb: FAIL");
		$finish;
	end

	initial begin
		req_in_t c;
		board = new();
		board.clear();
		clk = 0;
		arst_n = 0;
		start = 0;
		req = '0;
		send_idle = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: empty pop and peek, extremes, kinds zero to five and seven, fill to full.
		c = '0;
		c.op = OP_POP; send(c);
		c.op = OP_PEEK; send(c);
		c = '1;
		c.op = OP_PUSH_BACK; c.due_tick = 0; c.request_kind = 3'd7; send(c);
		c.op = OP_TICK; c.drive_error = ERR_NONE; send(c);
		for (int k = 0; k < 6; k++) begin
			c = rand_cmd(k[0] ? OP_PUSH_FRONT : OP_PUSH_BACK);
			c.request_kind = 3'(k); c.due_tick = 0; send(c);
		end
		c = rand_cmd(OP_FLUSH_STR); send(c);
		c = rand_cmd(OP_FLUSH_MUS); send(c);
		c = '0; c.op = OP_TICK; c.drive_accepts = 1; c.drive_busy = 1; send(c);
		c.drive_error = ERR_HARD; send(c);
		c.drive_error = ERR_NOT_READY; send(c);
		c.drive_error = ERR_NONE; c.drive_busy = 0; send(c);
		c.op = OP_NOP; send(c);
		for (int i = 0; i < 34; i++) send(rand_cmd(OP_PUSH_BACK));
		c = rand_cmd(OP_TICK); c.drive_error = ERR_HARD; send(c);
		c = rand_cmd(OP_PEEK); send(c);
		drain();
		for (int phase = 0; phase < 4; phase++) begin
			send_idle = phase == 1 ? 76 : phase == 3 ? 12 : 0;
			for (int i = 0; i < 430; i++) send(rand_cmd(rand_op()));
			drain();
		end
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("timed_read_request_queue_core_tb: PASS");
		end else begin
			$display("timed_read_request_queue_core_tb: FAIL");
		end
		$finish;
	end
endmodule
